// ===== sv/xed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xed_pkg
// Constants, microcode word layout, control store and entity tables for the
// predefined entity decoder.
// ----------------------------------------------------------------------------
package xed_pkg;

    localparam int HOLD_DEPTH = 4;
    localparam int NUM_ENT    = 5;
    localparam int CNT_W      = 3;
    localparam int IDX_W      = 2;

    localparam logic [7:0] AMP_CHAR = 8'h26;

    // sequencer steps
    localparam int STEP_W = 2;
    localparam logic [STEP_W-1:0] S_FETCH = 2'd0;
    localparam logic [STEP_W-1:0] S_AMP   = 2'd1;
    localparam logic [STEP_W-1:0] S_HELD  = 2'd2;
    localparam logic [STEP_W-1:0] S_PLAIN = 2'd3;

    // datapath source select
    localparam logic [1:0] SRC_DECODE = 2'd0;
    localparam logic [1:0] SRC_AMP    = 2'd1;
    localparam logic [1:0] SRC_HELD   = 2'd2;
    localparam logic [1:0] SRC_PLAIN  = 2'd3;

    // jump conditions
    localparam logic [1:0] COND_ALWAYS   = 2'd0;
    localparam logic [1:0] COND_MISMATCH = 2'd1;
    localparam logic [1:0] COND_CNT_ZERO = 2'd2;
    localparam logic [1:0] COND_IDX_END  = 2'd3;

    typedef struct packed {
        logic [1:0]        src;
        logic [1:0]        cond;
        logic [STEP_W-1:0] tgt_true;
        logic [STEP_W-1:0] tgt_false;
    } t_uword;

    function automatic t_uword uc_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        unique case (step)
            S_FETCH: w = '{SRC_DECODE, COND_MISMATCH, S_AMP,   S_FETCH};
            S_AMP:   w = '{SRC_AMP,    COND_CNT_ZERO, S_PLAIN, S_HELD};
            S_HELD:  w = '{SRC_HELD,   COND_IDX_END,  S_PLAIN, S_HELD};
            S_PLAIN: w = '{SRC_PLAIN,  COND_ALWAYS,   S_FETCH, S_FETCH};
            default: w = '{SRC_DECODE, COND_ALWAYS,   S_FETCH, S_FETCH};
        endcase
        return w;
    endfunction

    // entity body length: lt; gt; quot; amp; apos;
    function automatic logic [CNT_W-1:0] ent_len(input int e);
        logic [CNT_W-1:0] l;
        unique case (e)
            0:       l = 3'd3;
            1:       l = 3'd3;
            2:       l = 3'd5;
            3:       l = 3'd4;
            default: l = 3'd5;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] ent_repl(input int e);
        logic [7:0] c;
        unique case (e)
            0:       c = 8'h3C;
            1:       c = 8'h3E;
            2:       c = 8'h22;
            3:       c = 8'h26;
            default: c = 8'h27;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ent_body(input int e, input logic [CNT_W-1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (e)
            0: begin
                unique case (pos)
                    3'd0:    c = "l";
                    3'd1:    c = "t";
                    3'd2:    c = ";";
                    default: c = 8'h00;
                endcase
            end
            1: begin
                unique case (pos)
                    3'd0:    c = "g";
                    3'd1:    c = "t";
                    3'd2:    c = ";";
                    default: c = 8'h00;
                endcase
            end
            2: begin
                unique case (pos)
                    3'd0:    c = "q";
                    3'd1:    c = "u";
                    3'd2:    c = "o";
                    3'd3:    c = "t";
                    3'd4:    c = ";";
                    default: c = 8'h00;
                endcase
            end
            3: begin
                unique case (pos)
                    3'd0:    c = "a";
                    3'd1:    c = "m";
                    3'd2:    c = "p";
                    3'd3:    c = ";";
                    default: c = 8'h00;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0:    c = "a";
                    3'd1:    c = "p";
                    3'd2:    c = "o";
                    3'd3:    c = "s";
                    3'd4:    c = ";";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// ===== sv/xml_entity_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_entity_decoder
// Replaces &lt; &gt; &quot; &amp; &apos; in a byte stream, driven by a small
// microcoded sequencer over a hold buffer and an output register.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_stall    i_in_byte, i_in_last
//  output    out        o_out_valid / i_out_stall  o_out_byte, o_out_last,
//                                                  o_out_error
//
//  rate: one beat per cycle in the fetch step when the output is not stalled;
//    a mismatched entity then steps through the '&', each held byte and the
//    current byte (also when that byte is a restarting '&') before the next beat
//  replay steps stall the input; otherwise the output register passes a beat
//    every cycle while the output is not stalled
//  reset: synchronous active low; sequencer in fetch, no entity, empty hold
//  stalls: input is stalled outside the fetch step and whenever the output
//    register is full and stalled; a stalled output holds its beat
//
module xml_entity_decoder
    import xed_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_out_error
);

    // sequencer state
    logic [STEP_W-1:0] r_step, n_step;
    t_uword            uw;

    // matcher state
    logic                r_in_ent, n_in_ent;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [NUM_ENT-1:0]  r_alive, n_alive;
    logic [7:0]          r_held [HOLD_DEPTH];

    // captured beat for replay
    logic [7:0] r_byte;
    logic       r_last;

    // output register
    logic       r_ov, n_ov;
    logic [7:0] r_ob, n_ob;
    logic       r_ol, n_ol;
    logic       r_oe, n_oe;

    logic       out_free;
    logic       in_acc;
    logic       advance;
    logic       cond_hit;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       emit_err;
    logic       hold_wr;
    logic       cap_wr;

    // entity match on the incoming byte
    logic [NUM_ENT-1:0] hit;
    logic [NUM_ENT-1:0] full;
    logic [7:0]         full_char;
    logic               any_full;
    logic               any_prefix;
    logic               mismatch;

    assign uw       = uc_rom(r_step);
    assign out_free = !r_ov || !i_out_stall;
    assign in_acc   = (r_step == S_FETCH) && out_free && i_in_valid;

    always_comb begin
        full_char = 8'h00;
        for (int e = 0; e < NUM_ENT; e++) begin
            hit[e]  = r_alive[e] && (r_cnt < ent_len(e)) && (ent_body(e, r_cnt) == i_in_byte);
            full[e] = hit[e] && ((r_cnt + 3'd1) == ent_len(e));
            if (full[e]) begin
                full_char = ent_repl(e);
            end
        end
        any_full   = |full;
        any_prefix = |(hit & ~full);
        // hold only while a longer body can still match, the string goes on and the hold buffer has room
        mismatch   = r_in_ent && !any_full &&
                     !(any_prefix && !i_in_last && (r_cnt < 3'(HOLD_DEPTH)));
    end

    // conditional jump select
    always_comb begin
        unique case (uw.cond)
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_MISMATCH: cond_hit = mismatch;
            COND_CNT_ZERO: cond_hit = (r_cnt == '0);
            COND_IDX_END:  cond_hit = ({1'b0, r_idx} + 3'd1) == r_cnt;
            default:       cond_hit = 1'b1;
        endcase
    end

    // datapath driven by the control word
    always_comb begin
        emit      = 1'b0;
        emit_byte = 8'h00;
        emit_last = 1'b0;
        emit_err  = 1'b0;
        hold_wr   = 1'b0;
        cap_wr    = 1'b0;
        n_in_ent  = r_in_ent;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_alive   = r_alive;
        advance   = 1'b0;
        unique case (uw.src)
            SRC_DECODE: begin
                advance = in_acc;
                if (in_acc) begin
                    if (!r_in_ent) begin
                        if (i_in_byte == AMP_CHAR) begin
                            if (i_in_last) begin
                                emit     = 1'b1;
                                emit_last = 1'b1;
                                emit_err = 1'b1;
                            end else begin
                                n_in_ent = 1'b1;
                                n_alive  = '1;
                            end
                            n_cnt = '0;
                        end else begin
                            emit      = 1'b1;
                            emit_byte = i_in_byte;
                            emit_last = i_in_last;
                        end
                    end else if (any_full) begin
                        emit      = 1'b1;
                        emit_byte = full_char;
                        emit_last = i_in_last;
                        n_in_ent  = 1'b0;
                        n_cnt     = '0;
                    end else if (!mismatch) begin
                        hold_wr = 1'b1;
                        n_cnt   = r_cnt + 3'd1;
                        n_alive = hit;
                    end else begin
                        // replay path: count kept for the held-byte loop
                        cap_wr   = 1'b1;
                        n_in_ent = 1'b0;
                        n_idx    = '0;
                    end
                end
            end
            SRC_AMP: begin
                emit      = 1'b1;
                emit_byte = AMP_CHAR;
                advance   = out_free;
            end
            SRC_HELD: begin
                emit      = 1'b1;
                emit_byte = r_held[r_idx];
                advance   = out_free;
                if (out_free) begin
                    n_idx = r_idx + 2'd1;
                end
            end
            SRC_PLAIN: begin
                if (r_byte == AMP_CHAR) begin
                    if (r_last) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        emit_err  = 1'b1;
                        advance   = out_free;
                    end else begin
                        advance = 1'b1;
                    end
                    if (advance) begin
                        n_in_ent = !r_last;
                        n_alive  = '1;
                    end
                end else begin
                    emit      = 1'b1;
                    emit_byte = r_byte;
                    emit_last = r_last;
                    advance   = out_free;
                end
                if (advance) begin
                    n_cnt = '0;
                    n_idx = '0;
                end
            end
            default: begin
                advance = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (advance) begin
            n_step = cond_hit ? uw.tgt_true : uw.tgt_false;
        end
    end

    // output register: loads when free, clears when taken
    always_comb begin
        n_ov = r_ov;
        n_ob = r_ob;
        n_ol = r_ol;
        n_oe = r_oe;
        if (emit && out_free) begin
            n_ov = 1'b1;
            n_ob = emit_byte;
            n_ol = emit_last;
            n_oe = emit_err;
        end else if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= S_FETCH;
            r_in_ent <= 1'b0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_alive  <= '1;
            r_ov     <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_in_ent <= n_in_ent;
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_alive  <= n_alive;
            r_ov     <= n_ov;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_ob <= n_ob;
        r_ol <= n_ol;
        r_oe <= n_oe;
        if (cap_wr) begin
            r_byte <= i_in_byte;
            r_last <= i_in_last;
        end
        if (hold_wr) begin
            r_held[r_cnt[IDX_W-1:0]] <= i_in_byte;
        end
    end

    assign o_in_stall  = !((r_step == S_FETCH) && out_free);
    assign o_out_valid = r_ov;
    assign o_out_byte  = r_ob;
    assign o_out_last  = r_ol;
    assign o_out_error = r_oe;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(HOLD_DEPTH))
        else $error("hold count above buffer depth");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != S_FETCH) |-> o_in_stall)
        else $error("input not stalled during replay");

    a_held_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_HELD) |-> (r_cnt != '0) && ({1'b0, r_idx} < r_cnt))
        else $error("held replay with bad index");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_error) |-> o_out_last)
        else $error("error beat without last");

    a_amp_then_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_AMP && out_free) |=> (r_step == S_HELD || r_step == S_PLAIN))
        else $error("ampersand step did not advance to replay");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks xml_entity_decoder against a beat-level predictor of the entity
// matcher. Covers plain bytes, full entity matches, mismatch replays, early
// string ends and dangling ampersands, then a long random stream of mostly
// well-formed entities with idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import xed_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_BEATS   = 395;

    typedef struct packed {
        logic [7:0] data;
        logic       lst;
        logic       err;
    } t_dec_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic       o_out_error;

    xml_entity_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_out_error (o_out_error)
    );

    // entity bodies after the ampersand and the characters they stand for
    string      ent_text[NUM_ENT] = '{"lt;", "gt;", "quot;", "amp;", "apos;"};
    logic [7:0] ent_char[NUM_ENT] = '{8'h3C, 8'h3E, 8'h22, 8'h26, 8'h27};

    // predictor state
    logic [7:0] held_q[HOLD_DEPTH];
    int         held_cnt;
    bit         ent_active;

    t_dec_beat  decoded_q[$];

    int  mismatches;
    int  beats_in;
    int  beats_out;
    int  n_match;
    int  n_replay;
    int  n_amp_err;
    int  in_idle_pct;
    int  out_idle_pct;
    int  out_stall_left;
    int  quiet_cycles;
    bit  calm;

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    task automatic push_decoded(input logic [7:0] d, input logic l, input logic e);
        decoded_q.push_back('{data: d, lst: l, err: e});
    endtask

    // a byte seen outside an entity
    task automatic plain_text(input logic [7:0] b, input logic l);
        if (b == AMP_CHAR) begin
            if (l) begin
                push_decoded(8'h00, 1'b1, 1'b1);
                ent_active = 1'b0;
                n_amp_err++;
            end else begin
                ent_active = 1'b1;
            end
            held_cnt = 0;
        end else begin
            push_decoded(b, l, 1'b0);
        end
    endtask

    task automatic decode_beat(input logic [7:0] b, input logic l);
        logic [7:0] seq[HOLD_DEPTH+1];
        int         n;
        int         blen;
        bit         is_prefix;
        bit         same;
        if (!ent_active) begin
            plain_text(b, l);
            return;
        end
        for (int i = 0; i < held_cnt; i++) seq[i] = held_q[i];
        seq[held_cnt] = b;
        n = held_cnt + 1;
        is_prefix = 1'b0;
        for (int e = 0; e < NUM_ENT; e++) begin
            blen = ent_text[e].len();
            if (n > blen) continue;
            same = 1'b1;
            for (int i = 0; i < n; i++)
                if (seq[i] != ent_text[e][i]) same = 1'b0;
            if (!same) continue;
            if (n == blen) begin
                push_decoded(ent_char[e], l, 1'b0);
                ent_active = 1'b0;
                held_cnt = 0;
                n_match++;
                return;
            end
            is_prefix = 1'b1;
        end
        if (is_prefix && !l && n <= HOLD_DEPTH) begin
            held_q[n-1] = b;
            held_cnt = n;
            return;
        end
        // mismatch or early end: ampersand, held bytes, then this byte as text
        ent_active = 1'b0;
        held_cnt = 0;
        n_replay++;
        push_decoded(AMP_CHAR, 1'b0, 1'b0);
        for (int i = 0; i < n - 1; i++) push_decoded(seq[i], 1'b0, 1'b0);
        plain_text(b, l);
    endtask

    // ------------------------------------------------------------------------
    // input side: one beat, called and returning at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input logic l);
        if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_byte  = b;
        i_in_last  = l;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        decode_beat(b, l);
        beats_in++;
        @(negedge i_clk);
    endtask

    task automatic send_seq(input logic [7:0] q[$], input bit last_at_end);
        for (int i = 0; i < q.size(); i++)
            send_beat(q[i], last_at_end && (i == q.size() - 1));
    endtask

    task automatic send_text(input string s, input bit last_at_end);
        logic [7:0] q[$];
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        send_seq(q, last_at_end);
    endtask

    // ------------------------------------------------------------------------
    // output side: stall bursts and result checking
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (out_stall_left > 0)
            out_stall_left--;
        else if (!calm && i_rst_n && $urandom_range(0, 99) < out_idle_pct)
            out_stall_left = $urandom_range(1, 10);
        i_out_stall = (out_stall_left > 0);
    end

    always @(posedge i_clk) begin
        t_dec_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_out++;
            if (decoded_q.size() == 0) begin
                $error("unexpected beat: out_byte %02h out_last %0b out_error %0b",
                       o_out_byte, o_out_last, o_out_error);
                mismatches++;
            end else begin
                want = decoded_q.pop_front();
                // out_byte carries no meaning on an error beat
                if (!want.err && o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                    mismatches++;
                end
                if (o_out_last !== want.lst) begin
                    $error("out_last: expected %0b, got %0b", want.lst, o_out_last);
                    mismatches++;
                end
                if (o_out_error !== want.err) begin
                    $error("out_error: expected %0b, got %0b", want.err, o_out_error);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results pending",
                     quiet_cycles, decoded_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_plain_bytes();
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
    endtask

    task automatic test_entity_matches();
        send_text("&gt;", 1'b0);
        send_text("&quot;", 1'b1);
    endtask

    task automatic test_mismatch_replay();
        send_text("&&", 1'b0);      // second ampersand restarts the entity
        send_text("&apoX", 1'b0);   // three held bytes, then a miss
        send_text("&ap&", 1'b1);    // replayed ampersand ends the string
    endtask

    task automatic test_early_end();
        send_text("&l", 1'b1);
        send_text("&", 1'b1);
    endtask

    // mostly well-formed entities with random content, plus noise bytes
    task automatic test_random_stream(input int n_beats);
        logic [7:0] q[$];
        int         sent;
        int         e;
        int         cut;
        sent = 0;
        while (sent < n_beats) begin
            if (sent > n_beats * 4 / 5) begin
                calm = 1'b1;
            end else if ($urandom_range(0, 29) == 0) begin
                in_idle_pct  = $urandom_range(0, 2) * 15;
                out_idle_pct = $urandom_range(0, 2) * 15;
            end
            if ($urandom_range(0, 9) < 6) begin
                e = $urandom_range(0, NUM_ENT - 1);
                q.delete();
                q.push_back(AMP_CHAR);
                for (int i = 0; i < ent_text[e].len(); i++) q.push_back(ent_text[e][i]);
                case ($urandom_range(0, 5))
                    0: begin
                        // corrupt one body byte
                        cut = $urandom_range(1, q.size() - 1);
                        q[cut] = ($urandom_range(0, 3) == 0) ? AMP_CHAR
                                                            : 8'($urandom_range(0, 255));
                    end
                    1: begin
                        // cut short, sometimes at the end of the string
                        cut = $urandom_range(1, q.size() - 1);
                        while (q.size() > cut) void'(q.pop_back());
                    end
                    default: ;
                endcase
                send_seq(q, $urandom_range(0, 3) == 0);
                sent += q.size();
            end else begin
                send_beat(($urandom_range(0, 15) == 0) ? AMP_CHAR : 8'($urandom_range(0, 255)),
                          $urandom_range(0, 7) == 0);
                sent++;
            end
        end
        i_in_valid = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_byte      = 8'h00;
        i_in_last      = 1'b0;
        i_out_stall    = 1'b0;
        out_stall_left = 0;
        quiet_cycles   = 0;
        calm           = 1'b0;
        in_idle_pct    = 20;
        out_idle_pct   = 20;
        mismatches     = 0;
        beats_in       = 0;
        beats_out      = 0;
        n_match        = 0;
        n_replay       = 0;
        n_amp_err      = 0;
        held_cnt       = 0;
        ent_active     = 1'b0;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_plain_bytes();
        test_entity_matches();
        test_mismatch_replay();
        test_early_end();
        test_random_stream(RANDOM_BEATS);

        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d input beats, checked %0d decoded beats", beats_in, beats_out);
        $display("entity matches %0d, replays %0d, dangling ampersands %0d",
                 n_match, n_replay, n_amp_err);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
